// ===== src/ame_pkg.sv =====
// ----------------------------------------------------------------------------
// ame_pkg: shared types and constants for the alignment mismatch extractor
// Command and kind codes, the word layouts and the saturation helpers.
// ----------------------------------------------------------------------------
package ame_pkg;

  localparam int OFS_W = 32;
  localparam int LEN_W = 28;
  localparam int POS_W = 32;

  // command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_MATCH = 2'd1;
  localparam logic [1:0] CMD_OP    = 2'd2;

  // cigar operation kinds on the input side
  localparam logic [1:0] OP_SOFT_CLIP = 2'd0;
  localparam logic [1:0] OP_INSERT    = 2'd1;
  localparam logic [1:0] OP_DELETE    = 2'd2;
  localparam logic [1:0] OP_SKIP      = 2'd3;

  // record kinds on the output side
  localparam logic [1:0] KIND_MISMATCH  = 2'd0;
  localparam logic [1:0] KIND_INSERT    = 2'd1;
  localparam logic [1:0] KIND_DELETE    = 2'd2;
  localparam logic [1:0] KIND_CLIP_SKIP = 2'd3;

  localparam logic [15:0] SAT16 = 16'hFFFF;
  localparam logic [13:0] SAT14 = 14'h3FFF;

  typedef struct packed {
    logic [1:0]       command;
    logic [31:0]      start_position;
    logic [1:0]       ref_base_code;
    logic [1:0]       read_base_code;
    logic [1:0]       op_kind;
    logic [LEN_W-1:0] op_length;
  } item_t;

  typedef struct packed {
    logic [OFS_W-1:0] read_offset;
    logic [OFS_W-1:0] ref_offset;
    logic [OFS_W-1:0] joint_offset;
    logic [30:0]      read_start;
    logic             suppress_read;
  } walk_state_t;

  typedef struct packed {
    logic [POS_W-1:0] ref_position;
    logic [15:0]      read_offset_out;
    logic [15:0]      joint_offset_out;
    logic [1:0]       cigar_kind;
    logic [13:0]      cigar_length;
  } record_t;

  function automatic logic [OFS_W-1:0] sat_add(input logic [OFS_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [OFS_W:0] s;
    s = {1'b0, a} + {{(OFS_W+1-LEN_W){1'b0}}, b};
    return s[OFS_W] ? {OFS_W{1'b1}} : s[OFS_W-1:0];
  endfunction

  function automatic logic [15:0] sat16(input logic [OFS_W-1:0] a);
    return (|a[OFS_W-1:16]) ? SAT16 : a[15:0];
  endfunction

endpackage

// ===== src/ame_step.sv =====
// ----------------------------------------------------------------------------
// ame_step: per-word walk logic
// Builds the record for one word from the current offsets and computes the
// offsets and read start that follow it.
// ----------------------------------------------------------------------------
module ame_step
  import ame_pkg::*;
(
  input  item_t       item,
  input  walk_state_t st,
  output walk_state_t st_next,
  output logic        emit,
  output record_t     rec
);

  logic [13:0] len_sat;

  assign len_sat = (|item.op_length[LEN_W-1:14]) ? SAT14 : item.op_length[13:0];

  always_comb begin
    st_next              = st;
    emit                 = 1'b0;
    rec.ref_position     = {1'b0, st.read_start} + st.ref_offset;
    rec.read_offset_out  = sat16(st.read_offset);
    rec.joint_offset_out = sat16(st.joint_offset);
    rec.cigar_kind       = KIND_MISMATCH;
    rec.cigar_length     = 14'd1;

    case (item.command)
      CMD_START: begin
        st_next.read_offset  = '0;
        st_next.ref_offset   = '0;
        st_next.joint_offset = '0;
        // negative start mutes the whole read
        if (item.start_position[31]) begin
          st_next.suppress_read = 1'b1;
          st_next.read_start    = '0;
        end else begin
          st_next.suppress_read = 1'b0;
          st_next.read_start    = item.start_position[30:0];
        end
      end
      CMD_MATCH: begin
        if (!st.suppress_read) begin
          emit                 = (item.ref_base_code != item.read_base_code);
          st_next.read_offset  = sat_add(st.read_offset, LEN_W'(1));
          st_next.ref_offset   = sat_add(st.ref_offset, LEN_W'(1));
          st_next.joint_offset = sat_add(st.joint_offset, LEN_W'(1));
        end
      end
      CMD_OP: begin
        if (!st.suppress_read) begin
          emit                 = 1'b1;
          rec.cigar_length     = len_sat;
          st_next.joint_offset = sat_add(st.joint_offset, item.op_length);
          case (item.op_kind)
            OP_SOFT_CLIP: begin
              rec.cigar_kind      = KIND_CLIP_SKIP;
              st_next.read_offset = sat_add(st.read_offset, item.op_length);
              st_next.ref_offset  = sat_add(st.ref_offset, item.op_length);
            end
            OP_INSERT: begin
              rec.cigar_kind      = KIND_INSERT;
              st_next.read_offset = sat_add(st.read_offset, item.op_length);
            end
            OP_DELETE: begin
              rec.cigar_kind     = KIND_DELETE;
              st_next.ref_offset = sat_add(st.ref_offset, item.op_length);
            end
            default: begin
              rec.cigar_kind     = KIND_CLIP_SKIP;
              st_next.ref_offset = sat_add(st.ref_offset, item.op_length);
            end
          endcase
        end
      end
      default: begin
        // unused command: word is dropped
      end
    endcase
  end

endmodule

// ===== src/alignment_mismatch_extractor.sv =====
// ----------------------------------------------------------------------------
// alignment_mismatch_extractor: cigar walk with mismatch extraction
// Tracks read, reference and joint offsets of one aligned read and emits a
// record for every mismatch, clip, insertion, deletion or skip.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | command, start_position, ref_base_code,
//          |                      | read_base_code, op_kind, op_length
//  out     | out_valid / out_stall| ref_position, read_offset_out,
//          |                      | joint_offset_out, cigar_kind, cigar_length
//
// one word per cycle unless in_stall is high; a record is valid once its word has passed the word register and the walk
// has loaded the record register: stage 1 registers the word, stage 2 walks the offsets into the record register
// words that make no record (start, matching bases, muted read) leave no bubble
// in_stall rises only while the record register is full and out_stall is high
// rst clears the offsets, the read start, the mute flag and both valid flags
module alignment_mismatch_extractor
  import ame_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        command,
  input  logic signed [31:0] start_position,
  input  logic [1:0]        ref_base_code,
  input  logic [1:0]        read_base_code,
  input  logic [1:0]        op_kind,
  input  logic [LEN_W-1:0]  op_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [POS_W-1:0]  ref_position,
  output logic [15:0]       read_offset_out,
  output logic [15:0]       joint_offset_out,
  output logic [1:0]        cigar_kind,
  output logic [13:0]       cigar_length
);

  item_t       pend;
  logic        pend_valid;
  walk_state_t st;
  walk_state_t st_next;
  logic        emit;
  record_t     rec;
  record_t     out_rec;
  logic        advance;
  logic        in_take;

  assign advance  = pend_valid && (!out_valid || !out_stall);
  assign in_stall = pend_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  ame_step u_step (
    .item    (pend),
    .st      (st),
    .st_next (st_next),
    .emit    (emit),
    .rec     (rec)
  );

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_take) begin
      pend_valid <= 1'b1;
    end else if (advance) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      pend.command        <= command;
      pend.start_position <= start_position;
      pend.ref_base_code  <= ref_base_code;
      pend.read_base_code <= read_base_code;
      pend.op_kind        <= op_kind;
      pend.op_length      <= op_length;
    end
  end

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // record register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_rec <= rec;
    end
  end

  assign ref_position     = out_rec.ref_position;
  assign read_offset_out  = out_rec.read_offset_out;
  assign joint_offset_out = out_rec.joint_offset_out;
  assign cigar_kind       = out_rec.cigar_kind;
  assign cigar_length     = out_rec.cigar_length;

  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    (advance && pend.command == CMD_START) |=> !out_valid)
    else $error("start word produced a record");

  a_muted_silent: assert property (@(posedge clk) disable iff (rst)
    (advance && st.suppress_read) |=> !out_valid)
    else $error("record emitted while read is muted");

  a_mismatch_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && cigar_kind == KIND_MISMATCH) |-> cigar_length == 14'd1)
    else $error("mismatch record with length other than one");

  a_joint_ge_read: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> joint_offset_out >= read_offset_out)
    else $error("joint offset behind read offset");

endmodule

// ===== dv/tb_alignment_mismatch_extractor.sv =====
// ----------------------------------------------------------------------------
// tb_alignment_mismatch_extractor: self-checking bench for the mismatch extractor
// Drives reads of start, match, cigar-op and unused words with random gaps and
// output stalls, predicts records from a local model of the offset walk or takes
// them from directed rows and checks each one field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_alignment_mismatch_extractor;
  import ame_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int N_RANDOM   = 1800;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_WAIT  = 8;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_REC} check_e;

  typedef struct {
    item_t   w;
    check_e  chk;
    record_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = '0;
  logic signed [31:0] start_position = '0;
  logic [1:0] ref_base_code = '0;
  logic [1:0] read_base_code = '0;
  logic [1:0] op_kind = '0;
  logic [LEN_W-1:0] op_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [POS_W-1:0] ref_position;
  logic [15:0] read_offset_out;
  logic [15:0] joint_offset_out;
  logic [1:0] cigar_kind;
  logic [13:0] cigar_length;

  alignment_mismatch_extractor u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .start_position(start_position),
    .ref_base_code(ref_base_code), .read_base_code(read_base_code),
    .op_kind(op_kind), .op_length(op_length),
    .out_valid(out_valid), .out_stall(out_stall),
    .ref_position(ref_position), .read_offset_out(read_offset_out),
    .joint_offset_out(joint_offset_out), .cigar_kind(cigar_kind),
    .cigar_length(cigar_length)
  );

  always #5 clk = ~clk;

  // walk state of the predictor
  logic [31:0] trk_read, trk_ref, trk_joint;
  logic [30:0] trk_start;
  logic        trk_muted;

  record_t   records_due[$];
  stim_row_t directed_rows[$];
  check_e    cur_check = CHK_MODEL;
  record_t   cur_want = '0;
  bit        gaps_on = 1'b1;
  int        n_errors = 0;
  int        n_words = 0;
  int        n_records = 0;
  int        n_reads = 0;
  int        n_muted_reads = 0;
  int        idle_cycles = 0;

  function automatic logic [31:0] bump(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = a + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [15:0] clamp16(logic [31:0] a);
    return (a > 32'h0000_FFFF) ? 16'hFFFF : a[15:0];
  endfunction

  function automatic record_t event_record(logic [1:0] kind, logic [27:0] len);
    record_t r;
    r.ref_position     = {1'b0, trk_start} + trk_ref;
    r.read_offset_out  = clamp16(trk_read);
    r.joint_offset_out = clamp16(trk_joint);
    r.cigar_kind       = kind;
    r.cigar_length     = (len > 28'(SAT14)) ? SAT14 : len[13:0];
    return r;
  endfunction

  // advances the walk by one word; has is set when the word makes a record
  function automatic void walk_word(input item_t w, output bit has, output record_t r);
    has = 1'b0;
    r = '0;
    if (w.command == CMD_START) begin
      trk_read  = '0;
      trk_ref   = '0;
      trk_joint = '0;
      trk_muted = w.start_position[31];
      trk_start = w.start_position[31] ? 31'd0 : w.start_position[30:0];
    end else if (w.command == CMD_MATCH && !trk_muted) begin
      if (w.ref_base_code != w.read_base_code) begin
        has = 1'b1;
        r = event_record(KIND_MISMATCH, 28'd1);
      end
      trk_read  = bump(trk_read, 32'd1);
      trk_ref   = bump(trk_ref, 32'd1);
      trk_joint = bump(trk_joint, 32'd1);
    end else if (w.command == CMD_OP && !trk_muted) begin
      has = 1'b1;
      case (w.op_kind)
        OP_SOFT_CLIP: begin
          r = event_record(KIND_CLIP_SKIP, w.op_length);
          trk_read = bump(trk_read, 32'(w.op_length));
          trk_ref  = bump(trk_ref, 32'(w.op_length));
        end
        OP_INSERT: begin
          r = event_record(KIND_INSERT, w.op_length);
          trk_read = bump(trk_read, 32'(w.op_length));
        end
        OP_DELETE: begin
          r = event_record(KIND_DELETE, w.op_length);
          trk_ref = bump(trk_ref, 32'(w.op_length));
        end
        default: begin
          r = event_record(KIND_CLIP_SKIP, w.op_length);
          trk_ref = bump(trk_ref, 32'(w.op_length));
        end
      endcase
      trk_joint = bump(trk_joint, 32'(w.op_length));
    end
  endfunction

  function automatic void cmp(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      n_errors++;
    end
  endfunction

  function automatic record_t rec(logic [31:0] pos, logic [15:0] rd, logic [15:0] jt,
                                  logic [1:0] kind, logic [13:0] len);
    return {pos, rd, jt, kind, len};
  endfunction

  function automatic void put(logic [1:0] cmd, logic [31:0] pos, logic [1:0] rb,
                              logic [1:0] qb, logic [1:0] kind, logic [27:0] len,
                              check_e chk, record_t want);
    stim_row_t s;
    s.w = {cmd, pos, rb, qb, kind, len};
    s.chk = chk;
    s.want = want;
    directed_rows.insert(directed_rows.size(), s);
  endfunction

  // checks records on the way out and predicts words on the way in
  always @(posedge clk) begin : monitor
    record_t got, want, pr;
    item_t   w;
    bit      has;
    if (!rst) begin
      idle_cycles++;
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        n_records++;
        got = {ref_position, read_offset_out, joint_offset_out, cigar_kind, cigar_length};
        if (records_due.size() == 0) begin
          $display("%0t: unexpected record, expected none, got %h", $time, got);
          n_errors++;
        end else begin
          want = records_due.pop_front();
          cmp("ref_position", want.ref_position, got.ref_position);
          cmp("read_offset_out", 32'(want.read_offset_out), 32'(got.read_offset_out));
          cmp("joint_offset_out", 32'(want.joint_offset_out), 32'(got.joint_offset_out));
          cmp("cigar_kind", 32'(want.cigar_kind), 32'(got.cigar_kind));
          cmp("cigar_length", 32'(want.cigar_length), 32'(got.cigar_length));
        end
      end
      if (in_valid && !in_stall) begin
        idle_cycles = 0;
        w = {command, start_position, ref_base_code, read_base_code, op_kind, op_length};
        n_words++;
        if (w.command == CMD_START) begin
          n_reads++;
          if (w.start_position[31])
            n_muted_reads++;
        end
        walk_word(w, has, pr);
        if (cur_check == CHK_NONE) begin
          has = 1'b0;
        end else if (cur_check == CHK_REC) begin
          has = 1'b1;
          pr = cur_want;
        end
        if (has)
          records_due.insert(records_due.size(), pr);
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d records outstanding",
                 $time, idle_cycles, records_due.size());
        $display("tb_alignment_mismatch_extractor: done, errors");
        $finish;
      end
    end
  end

  always @(negedge clk)
    out_stall = gaps_on && ($urandom_range(99) < 23);

  // called just after a falling edge, returns just after one
  task automatic send_word(input item_t w, input check_e chk, input record_t want);
    while (gaps_on && $urandom_range(99) < 23) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    command        = w.command;
    start_position = w.start_position;
    ref_base_code  = w.ref_base_code;
    read_base_code = w.read_base_code;
    op_kind        = w.op_kind;
    op_length      = w.op_length;
    cur_check      = chk;
    cur_want       = want;
    in_valid       = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (records_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    item_t w;
    int base, n, sel, match_pct;
    bit big, paused;

    trk_read  = '0;
    trk_ref   = '0;
    trk_joint = '0;
    trk_start = '0;
    trk_muted = 1'b0;

    // match before any start, then a read at 100
    put(CMD_MATCH, 0, 2'd0, 2'd1, 0, 0, CHK_REC, rec(0, 0, 0, KIND_MISMATCH, 1));
    put(CMD_START, 100, 0, 0, 0, 0, CHK_NONE, '0);
    put(CMD_MATCH, 0, 2'd2, 2'd2, 0, 0, CHK_NONE, '0);
    put(CMD_MATCH, 0, 2'd0, 2'd3, 0, 0, CHK_REC, rec(101, 1, 1, KIND_MISMATCH, 1));
    put(CMD_OP, 0, 0, 0, OP_SOFT_CLIP, 5, CHK_REC, rec(102, 2, 2, KIND_CLIP_SKIP, 5));
    put(CMD_OP, 0, 0, 0, OP_INSERT, 3, CHK_REC, rec(107, 7, 7, KIND_INSERT, 3));
    put(CMD_OP, 0, 0, 0, OP_DELETE, 0, CHK_REC, rec(107, 10, 10, KIND_DELETE, 0));
    put(CMD_OP, 0, 0, 0, OP_SKIP, 28'hFFF_FFFF, CHK_REC,
        rec(107, 10, 10, KIND_CLIP_SKIP, SAT14));
    put(CMD_OP, 0, 0, 0, OP_DELETE, 16383, CHK_MODEL, '0);
    put(CMD_OP, 0, 0, 0, OP_INSERT, 16384, CHK_MODEL, '0);
    put(CMD_MATCH, 0, 2'd3, 2'd3, 0, 0, CHK_MODEL, '0);
    put(CMD_UNUSED, 32'hFFFF_FFFF, 2'd3, 2'd0, 2'd3, 28'hFFF_FFFF, CHK_NONE, '0);
    put(CMD_MATCH, 0, 2'd1, 2'd2, 0, 0, CHK_MODEL, '0);
    // negative start mutes the read
    put(CMD_START, 32'h8000_0000, 0, 0, 0, 0, CHK_NONE, '0);
    put(CMD_MATCH, 0, 2'd0, 2'd1, 0, 0, CHK_NONE, '0);
    put(CMD_OP, 0, 0, 0, OP_INSERT, 9, CHK_NONE, '0);
    put(CMD_START, 32'h7FFF_FFFF, 0, 0, 0, 0, CHK_NONE, '0);
    put(CMD_OP, 0, 0, 0, OP_SKIP, 28'hFFF_FFFF, CHK_REC,
        rec(32'h7FFF_FFFF, 0, 0, KIND_CLIP_SKIP, SAT14));
    put(CMD_MATCH, 0, 2'd2, 2'd1, 0, 0, CHK_MODEL, '0);
    // read offset past 16 bits
    put(CMD_START, 0, 0, 0, 0, 0, CHK_NONE, '0);
    put(CMD_OP, 0, 0, 0, OP_INSERT, 70000, CHK_REC, rec(0, 0, 0, KIND_INSERT, SAT14));
    put(CMD_MATCH, 0, 2'd3, 2'd0, 0, 0, CHK_REC, rec(0, SAT16, SAT16, KIND_MISMATCH, 1));
    put(CMD_START, 32'hFFFF_FFFF, 0, 0, 0, 0, CHK_NONE, '0);
    put(CMD_OP, 0, 0, 0, OP_SOFT_CLIP, 1, CHK_NONE, '0);
    put(CMD_START, 0, 0, 0, 0, 0, CHK_NONE, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_word(directed_rows[i].w, directed_rows[i].chk, directed_rows[i].want);
    wait_drained();

    base = n_words;
    paused = 1'b0;
    while (n_words - base < N_RANDOM) begin
      gaps_on = !((n_words - base >= 600) && (n_words - base < 900));
      if (!paused && n_words - base >= 1100) begin
        wait_drained();
        paused = 1'b1;
      end
      // most reads open with a start; the rest continue the previous walk
      if ($urandom_range(9) != 0) begin
        w = {CMD_START, 32'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
             28'($urandom)};
        sel = $urandom_range(19);
        if (sel < 2)
          w.start_position = $urandom | 32'h8000_0000;
        else if (sel < 4)
          w.start_position = 32'h7FFF_FFFF - $urandom_range(255);
        else if (sel < 7)
          w.start_position = $urandom_range(1000);
        else
          w.start_position = $urandom & 32'h7FFF_FFFF;
        send_word(w, CHK_MODEL, '0);
      end
      // big reads carry long ops that saturate the offsets and wrap the position
      big = ($urandom_range(7) == 0);
      n = big ? $urandom_range(1, 60) : $urandom_range(1, 40);
      match_pct = big ? 30 : 68;
      repeat (n) begin
        w = {CMD_MATCH, 32'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
             28'($urandom)};
        sel = $urandom_range(99);
        if (sel < 3) begin
          w.command = CMD_UNUSED;
        end else if (sel < match_pct) begin
          if ($urandom_range(3) != 0)
            w.read_base_code = w.ref_base_code;
        end else begin
          w.command = CMD_OP;
          if (big)
            w.op_length = $urandom_range(1) ? 28'hFFF_FFFF - 28'($urandom_range(15))
                                            : 28'($urandom);
          else if ($urandom_range(19) == 0)
            w.op_length = 28'($urandom_range(20000));
          else
            w.op_length = 28'($urandom_range(40));
        end
        send_word(w, CHK_MODEL, '0);
      end
    end

    gaps_on = 1'b1;
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (records_due.size() != 0) begin
      $display("%0t: %0d records never arrived", $time, records_due.size());
      n_errors++;
    end
    $display("covered %0d words over %0d reads (%0d muted), %0d records checked",
             n_words, n_reads, n_muted_reads, n_records);
    if (n_errors == 0)
      $display("tb_alignment_mismatch_extractor: done, clean");
    else
      $display("tb_alignment_mismatch_extractor: done, errors");
    $finish;
  end

endmodule
